// ===== hw/rtl/ray_sphere_intersect_defines.svh =====
// ---------------------------------------------------------------------------
// Ray/sphere intersector assertion macros
// Shared concurrent assertion forms for the ray/sphere RTL.
// ---------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RSI_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rsi assertion failed");

// next-cycle implication, disabled in reset
`define RSI_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rsi assertion failed");

`endif

// ===== hw/rtl/rsi_pkg.sv =====
// ---------------------------------------------------------------------------
// Ray/sphere intersector package
// Formats, word types and config register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  localparam int COORD_W  = 32;            // Q16.16 positions
  localparam int DIR_W    = 32;            // Q2.30 directions
  localparam int DIR_FRAC = 30;
  localparam int RAD_W    = COORD_W - 1;   // unsigned radius
  localparam int CFG_W    = 32;

  localparam int L_W    = COORD_W + 1;     // center - origin
  localparam int PB_W   = L_W + DIR_W;     // dir * L
  localparam int PL_W   = 2 * L_W;         // L * L
  localparam int RR_W   = 2 * RAD_W;       // r * r
  localparam int BW_W   = PB_W + 2;        // sum of three dir*L
  localparam int C_W    = PL_W + 2;        // L.L - r*r
  localparam int B_W    = BW_W - DIR_FRAC; // b in Q.16
  localparam int BB_W   = 2 * B_W;
  localparam int DISC_W = 76;              // even, covers b*b - c
  localparam int ROOT_W = DISC_W / 2;
  localparam int REM_W  = ROOT_W + 4;
  localparam int T_W    = ROOT_W + 2;      // signed t
  localparam int PD_W   = T_W + DIR_W;     // dir * t
  localparam int ST_W   = PD_W - DIR_FRAC; // step in Q.16
  localparam int SUM_W  = ST_W + 1;

  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
  } in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } out_t;

  // travels alongside the square root pipe
  typedef struct packed {
    logic                  hit;
    logic signed [B_W-1:0] b;
    in_t                   ray;
  } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ray_sphere_intersect.sv =====
// Path: registers S1 to S5, the square root stages, S6, S7 and the output word.
// Throughput: one ray per cycle; the whole pipe moves on one enable and holds
//   in place while the output word waits for out_ready.
// Square root: 38 stages, one root bit each, set most of the latency.
// Reset: synchronous active-low rst_n clears all valid bits, center to 0 and
//   radius to 1.0; no clearing pass.
// ---------------------------------------------------------------------------
// Ray/sphere intersector
// Pipelined ray against configured sphere, returns hit flag and hit point.
// ---------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // ray input
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire rsi_pkg::in_t               in_data,
  // result output
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output rsi_pkg::out_t                   out_data,
  // config writes
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_addr,
  input  wire logic [rsi_pkg::CFG_W-1:0]  cfg_wdata
);

  // ------------------------------------------------------------------
  // Config registers
  // ------------------------------------------------------------------
  logic signed [rsi_pkg::COORD_W-1:0] center_r [3];
  logic [rsi_pkg::RAD_W-1:0]          radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
      radius_r    <= rsi_pkg::RAD_W'(65536);
    end else if (cfg_we) begin
      unique case (rsi_pkg::cfg_idx_t'(cfg_addr))
        rsi_pkg::CFG_CENTER_X: center_r[0] <= cfg_wdata[rsi_pkg::COORD_W-1:0];
        rsi_pkg::CFG_CENTER_Y: center_r[1] <= cfg_wdata[rsi_pkg::COORD_W-1:0];
        rsi_pkg::CFG_CENTER_Z: center_r[2] <= cfg_wdata[rsi_pkg::COORD_W-1:0];
        rsi_pkg::CFG_RADIUS:   radius_r    <= cfg_wdata[rsi_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Pipe enable: everything advances unless the output word is stuck.
  // ------------------------------------------------------------------
  logic en;
  logic out_valid_r;
  rsi_pkg::out_t out_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // ray unpacked into per-axis arrays
  logic signed [rsi_pkg::COORD_W-1:0] in_org [3];
  logic signed [rsi_pkg::DIR_W-1:0]   in_dir [3];
  assign in_org[0] = in_data.origin_x;
  assign in_org[1] = in_data.origin_y;
  assign in_org[2] = in_data.origin_z;
  assign in_dir[0] = in_data.dir_x;
  assign in_dir[1] = in_data.dir_y;
  assign in_dir[2] = in_data.dir_z;

  // ------------------------------------------------------------------
  // S1: L = center - origin
  // ------------------------------------------------------------------
  logic                               v1_r;
  logic signed [rsi_pkg::L_W-1:0]     l1_r   [3];
  logic signed [rsi_pkg::COORD_W-1:0] org1_r [3];
  logic signed [rsi_pkg::DIR_W-1:0]   dir1_r [3];

  // ------------------------------------------------------------------
  // S2: products dir*L, L*L, r*r
  // ------------------------------------------------------------------
  logic                               v2_r;
  logic signed [rsi_pkg::PB_W-1:0]    pb2_r  [3];
  logic signed [rsi_pkg::PL_W-1:0]    pl2_r  [3];
  logic [rsi_pkg::RR_W-1:0]           rr2_r;
  logic signed [rsi_pkg::COORD_W-1:0] org2_r [3];
  logic signed [rsi_pkg::DIR_W-1:0]   dir2_r [3];

  // ------------------------------------------------------------------
  // S3: b = floor(D.L / 2^30), c = L.L - r^2
  // ------------------------------------------------------------------
  logic                               v3_r;
  logic signed [rsi_pkg::B_W-1:0]     b3_r;
  logic signed [rsi_pkg::C_W-1:0]     c3_r;
  logic signed [rsi_pkg::COORD_W-1:0] org3_r [3];
  logic signed [rsi_pkg::DIR_W-1:0]   dir3_r [3];
  logic [rsi_pkg::BW_W-1:0]           bw_nxt;
  logic [rsi_pkg::C_W-1:0]            c_nxt;

  // ------------------------------------------------------------------
  // S4: b^2
  // ------------------------------------------------------------------
  logic                               v4_r;
  logic signed [rsi_pkg::BB_W-1:0]    bb4_r;
  logic signed [rsi_pkg::B_W-1:0]     b4_r;
  logic signed [rsi_pkg::C_W-1:0]     c4_r;
  logic signed [rsi_pkg::COORD_W-1:0] org4_r [3];
  logic signed [rsi_pkg::DIR_W-1:0]   dir4_r [3];

  // ------------------------------------------------------------------
  // S5: disc = b^2 - c, hit = disc >= 0
  // ------------------------------------------------------------------
  logic                               v5_r;
  logic [rsi_pkg::DISC_W-1:0]         rad5_r;
  rsi_pkg::side_t                     side5_r;
  logic [rsi_pkg::DISC_W-1:0]         disc_nxt;
  rsi_pkg::side_t                     side_nxt;

  always_comb begin
    disc_nxt = rsi_pkg::DISC_W'(bb4_r) - rsi_pkg::DISC_W'(c4_r);
    side_nxt.hit          = !disc_nxt[rsi_pkg::DISC_W-1];
    side_nxt.b            = b4_r;
    side_nxt.ray.origin_x = org4_r[0];
    side_nxt.ray.origin_y = org4_r[1];
    side_nxt.ray.origin_z = org4_r[2];
    side_nxt.ray.dir_x    = dir4_r[0];
    side_nxt.ray.dir_y    = dir4_r[1];
    side_nxt.ray.dir_z    = dir4_r[2];
  end

  always_comb begin
    bw_nxt = rsi_pkg::BW_W'(pb2_r[0]) + rsi_pkg::BW_W'(pb2_r[1])
           + rsi_pkg::BW_W'(pb2_r[2]);
    c_nxt  = rsi_pkg::C_W'(pl2_r[0]) + rsi_pkg::C_W'(pl2_r[1])
           + rsi_pkg::C_W'(pl2_r[2]) - rsi_pkg::C_W'(rr2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l1_r[i]   <= rsi_pkg::L_W'(center_r[i]) - rsi_pkg::L_W'(in_org[i]);
        org1_r[i] <= in_org[i];
        dir1_r[i] <= in_dir[i];
        pb2_r[i]  <= l1_r[i] * dir1_r[i];
        pl2_r[i]  <= l1_r[i] * l1_r[i];
        org2_r[i] <= org1_r[i];
        dir2_r[i] <= dir1_r[i];
        org3_r[i] <= org2_r[i];
        dir3_r[i] <= dir2_r[i];
        org4_r[i] <= org3_r[i];
        dir4_r[i] <= dir3_r[i];
      end
      rr2_r   <= radius_r * radius_r;
      b3_r    <= bw_nxt[rsi_pkg::BW_W-1:rsi_pkg::DIR_FRAC];
      c3_r    <= c_nxt;
      bb4_r   <= b3_r * b3_r;
      b4_r    <= b3_r;
      c4_r    <= c3_r;
      rad5_r  <= side_nxt.hit ? disc_nxt : '0;
      side5_r <= side_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Square root pipe
  // ------------------------------------------------------------------
  logic                       vq;
  logic [rsi_pkg::ROOT_W-1:0] sq_root;
  rsi_pkg::side_t             sq_side;

  rsi_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_rad    (rad5_r),
    .in_side   (side5_r),
    .out_valid (vq),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ------------------------------------------------------------------
  // S6: t = b - s if that is >= 0, else |b + s|
  // ------------------------------------------------------------------
  logic                           v6_r;
  logic signed [rsi_pkg::T_W-1:0] t6_r;
  rsi_pkg::side_t                 side6_r;
  logic [rsi_pkg::T_W-1:0]        bx, sx, tn, bs, t_nxt;

  always_comb begin
    bx = rsi_pkg::T_W'(sq_side.b);
    sx = {2'b00, sq_root};
    tn = bx - sx;
    bs = bx + sx;
    if (!tn[rsi_pkg::T_W-1]) begin
      t_nxt = tn;
    end else if (bs[rsi_pkg::T_W-1]) begin
      t_nxt = -bs;
    end else begin
      t_nxt = bs;
    end
  end

  // ------------------------------------------------------------------
  // S7: dir * t
  // ------------------------------------------------------------------
  logic                               v7_r;
  logic                               hit7_r;
  logic signed [rsi_pkg::PD_W-1:0]    pd7_r  [3];
  logic signed [rsi_pkg::COORD_W-1:0] org7_r [3];
  logic signed [rsi_pkg::DIR_W-1:0]   dir6   [3];
  logic signed [rsi_pkg::COORD_W-1:0] org6   [3];

  assign dir6[0] = side6_r.ray.dir_x;
  assign dir6[1] = side6_r.ray.dir_y;
  assign dir6[2] = side6_r.ray.dir_z;
  assign org6[0] = side6_r.ray.origin_x;
  assign org6[1] = side6_r.ray.origin_y;
  assign org6[2] = side6_r.ray.origin_z;

  // ------------------------------------------------------------------
  // S8 (output word): origin + floor(dir*t / 2^30), zero on a miss, else saturated
  // ------------------------------------------------------------------
  logic [rsi_pkg::SUM_W-1:0]   sum    [3];
  logic [rsi_pkg::COORD_W-1:0] pt_nxt [3];
  rsi_pkg::out_t               out_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = rsi_pkg::SUM_W'(org7_r[i])
             + rsi_pkg::SUM_W'($signed(pd7_r[i][rsi_pkg::PD_W-1:rsi_pkg::DIR_FRAC]));
      if (sum[i][rsi_pkg::SUM_W-1:rsi_pkg::COORD_W-1] == '0 ||
          sum[i][rsi_pkg::SUM_W-1:rsi_pkg::COORD_W-1] == '1) begin
        pt_nxt[i] = sum[i][rsi_pkg::COORD_W-1:0];
      end else if (sum[i][rsi_pkg::SUM_W-1]) begin
        pt_nxt[i] = {1'b1, {(rsi_pkg::COORD_W-1){1'b0}}};
      end else begin
        pt_nxt[i] = {1'b0, {(rsi_pkg::COORD_W-1){1'b1}}};
      end
      if (!hit7_r) begin
        pt_nxt[i] = '0;
      end
    end
    out_nxt.hit     = hit7_r;
    out_nxt.point_x = pt_nxt[0];
    out_nxt.point_y = pt_nxt[1];
    out_nxt.point_z = pt_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v6_r        <= vq;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t6_r    <= t_nxt;
      side6_r <= sq_side;
      hit7_r  <= side6_r.hit;
      for (int i = 0; i < 3; i++) begin
        pd7_r[i]  <= t6_r * dir6[i];
        org7_r[i] <= org6[i];
      end
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
`include "ray_sphere_intersect_defines.svh"

  // a miss always reports the origin-free zero point
  `RSI_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid_r && !out_r.hit,
    out_r.point_x == '0 && out_r.point_y == '0 && out_r.point_z == '0)

  // selected distance is never negative
  `RSI_ASSERT_IMP(a_t_nonneg, clk, rst_n, v6_r, !t6_r[rsi_pkg::T_W-1])

  // a stalled pipe keeps its occupancy
  `RSI_ASSERT_NXT(a_stall_hold, clk, rst_n, !en,
    $stable(v5_r) && $stable(v6_r) && $stable(v7_r) && $stable(out_valid_r))

endmodule

`default_nettype wire

// ===== hw/rtl/rsi_sqrt.sv =====
// ---------------------------------------------------------------------------
// Ray/sphere square root pipe
// Floor square root, one result bit per register stage, with sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module rsi_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [rsi_pkg::DISC_W-1:0]    in_rad,
  input  wire rsi_pkg::side_t                in_side,
  output logic                               out_valid,
  output logic [rsi_pkg::ROOT_W-1:0]         out_root,
  output rsi_pkg::side_t                     out_side
);

  localparam int NS = rsi_pkg::ROOT_W;

  logic                         v_r    [NS];
  logic [rsi_pkg::DISC_W-1:0]   rad_r  [NS];
  logic [rsi_pkg::REM_W-1:0]    rem_r  [NS];
  logic [rsi_pkg::ROOT_W-1:0]   root_r [NS];
  rsi_pkg::side_t               side_r [NS];

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_stage
      logic                       v_i;
      logic [rsi_pkg::DISC_W-1:0] rad_i;
      logic [rsi_pkg::REM_W-1:0]  rem_i;
      logic [rsi_pkg::ROOT_W-1:0] root_i;
      rsi_pkg::side_t             side_i;
      logic [rsi_pkg::REM_W-1:0]  rem_sh;
      logic [rsi_pkg::REM_W-1:0]  trial;
      logic [rsi_pkg::DISC_W-1:0] rad_nxt;
      logic [rsi_pkg::REM_W-1:0]  rem_nxt;
      logic [rsi_pkg::ROOT_W-1:0] root_nxt;

      if (g == 0) begin : g_first
        assign v_i    = in_valid;
        assign rad_i  = in_rad;
        assign rem_i  = '0;
        assign root_i = '0;
        assign side_i = in_side;
      end else begin : g_next
        assign v_i    = v_r[g-1];
        assign rad_i  = rad_r[g-1];
        assign rem_i  = rem_r[g-1];
        assign root_i = root_r[g-1];
        assign side_i = side_r[g-1];
      end

      always_comb begin
        rem_sh  = {rem_i[rsi_pkg::REM_W-3:0], rad_i[rsi_pkg::DISC_W-1 -: 2]};
        trial   = {2'b00, root_i, 2'b01};
        rad_nxt = {rad_i[rsi_pkg::DISC_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_i[rsi_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_i[rsi_pkg::ROOT_W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[g] <= 1'b0;
        end else if (en) begin
          v_r[g] <= v_i;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[g]  <= rad_nxt;
          rem_r[g]  <= rem_nxt;
          root_r[g] <= root_nxt;
          side_r[g] <= side_i;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

`default_nettype wire
